@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is low.
`define BSMH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define BSMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bsmh_pkg.sv @@
// Types, constants and the mix step function of the byte-serial lookup2 hash.
package bsmh_pkg;

   // Initial value of words a and b for every message.
   localparam logic [31:0] GOLDEN_RATIO = 32'h9e37_79b9;

   // Index of the last of the nine mix steps, and of the last byte of a block.
   localparam logic [3:0] MIX_LAST_STEP = 4'd8;
   localparam logic [3:0] BLOCK_LAST_POS = 4'd11;

   // Roles of the mix steps: which word a step rewrites.
   localparam logic [1:0] ROLE_A = 2'd0;
   localparam logic [1:0] ROLE_B = 2'd1;
   localparam logic [1:0] ROLE_C = 2'd2;

   // One queued word, already classified by the front end.
   typedef struct packed {
      logic        first;
      logic        present;
      logic        last;
      logic [7:0]  data_byte;
      logic [31:0] seed;
   } entry_type;

   // States of the back end.
   typedef enum logic [1:0] {
      ST_TAKE,
      ST_MIX,
      ST_FINAL,
      ST_EMIT
   } back_state_type;

   // One step of the mix: x -= y; x -= z; x ^= shifted z.
   function automatic logic [31:0] mix_step(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z, input logic [3:0] step);
      logic [31:0] diff;
      logic [31:0] sh;
      diff = x - y - z;
      case (step)
         4'd0:    sh = z >> 13;
         4'd1:    sh = z << 8;
         4'd2:    sh = z >> 13;
         4'd3:    sh = z >> 12;
         4'd4:    sh = z << 16;
         4'd5:    sh = z >> 5;
         4'd6:    sh = z >> 3;
         4'd7:    sh = z << 10;
         4'd8:    sh = z >> 15;
         default: sh = '0;
      endcase
      return diff ^ sh;
   endfunction

endpackage

@@ rtl/core/bsmh_front.sv @@
// Front end: accepts input words and marks the first word of each message.
module bsmh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_present,
   input  logic                req_last_item,
   input  logic [31:0]         req_seed,
   output logic                push_valid,
   input  logic                push_ready,
   output bsmh_pkg::entry_type push_entry
);

   logic inside_ff;
   logic inside_in;

   // A word is taken whenever the queue has room.
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // Classify the word: it opens a message when none is open.
   always_comb begin
      push_entry.first     = ~inside_ff;
      push_entry.present   = req_byte_present;
      push_entry.last      = req_last_item;
      push_entry.data_byte = req_data_byte;
      push_entry.seed      = req_seed;
   end

   // Track whether a message is open; the last word closes it.
   always_comb begin
      inside_in = inside_ff;
      if (req_valid && push_ready) begin
         inside_in = ~req_last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
      end
   end

endmodule

@@ rtl/core/bsmh_queue.sv @@
// Short queue of classified words between the front and back ends.
module bsmh_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  bsmh_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output bsmh_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bsmh_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/bsmh_back.sv @@
// Back end: packs bytes into the hash words, runs the mix and holds the result.
module bsmh_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  bsmh_pkg::entry_type pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_hash_value
);

   bsmh_pkg::back_state_type state_ff;
   bsmh_pkg::back_state_type state_in;

   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] c_ff, c_in;
   logic [23:0] pend_ff, pend_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  role_ff, role_in;
   logic        fin_ff, fin_in;
   logic        close_ff, close_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] hash_ff, hash_in;

   // Word values at the start of the current word, after a message opens.
   logic [31:0] a0, b0, c0, len0;
   logic [23:0] pend0;
   logic [3:0]  pos0;
   logic [4:0]  byte_sh;
   logic [31:0] mix_x, mix_y, mix_z, mix_new;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;
   assign pop_ready      = (state_ff == bsmh_pkg::ST_TAKE);

   // Operand routing for one mix step: the role picks the word rewritten.
   always_comb begin
      case (role_ff)
         bsmh_pkg::ROLE_A: begin
            mix_x = a_ff;
            mix_y = b_ff;
            mix_z = c_ff;
         end
         bsmh_pkg::ROLE_B: begin
            mix_x = b_ff;
            mix_y = c_ff;
            mix_z = a_ff;
         end
         default: begin
            mix_x = c_ff;
            mix_y = a_ff;
            mix_z = b_ff;
         end
      endcase
      mix_new = bsmh_pkg::mix_step(mix_x, mix_y, mix_z, step_ff);
   end

   // Start values: a message's first word reloads the hash words, pending bytes, length and position.
   always_comb begin
      a0    = pop_entry.first ? bsmh_pkg::GOLDEN_RATIO : a_ff;
      b0    = pop_entry.first ? bsmh_pkg::GOLDEN_RATIO : b_ff;
      c0    = pop_entry.first ? pop_entry.seed : c_ff;
      pend0 = pop_entry.first ? '0 : pend_ff;
      len0  = pop_entry.first ? '0 : len_ff;
      pos0  = (pop_entry.first || pos_ff > bsmh_pkg::BLOCK_LAST_POS) ? '0 : pos_ff;
      byte_sh = {pos0[1:0], 3'b000};
   end

   // Next state and datapath.
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      pend_in      = pend_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      role_in      = role_ff;
      fin_in       = fin_ff;
      close_in     = close_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         bsmh_pkg::ST_TAKE: begin
            if (pop_valid) begin
               a_in     = a0;
               b_in     = b0;
               c_in     = c0;
               pend_in  = pend0;
               pos_in   = pos0;
               len_in   = len0;
               step_in  = '0;
               role_in  = bsmh_pkg::ROLE_A;
               fin_in   = 1'b0;
               close_in = pop_entry.last;
               if (pop_entry.last) begin
                  state_in = bsmh_pkg::ST_FINAL;
               end
               if (pop_entry.present) begin
                  len_in = len0 + 32'd1;
                  pos_in = (pos0 == bsmh_pkg::BLOCK_LAST_POS) ? '0 : pos0 + 4'd1;
                  case (pos0) inside
                     [4'd0:4'd3]: a_in = a0 + ({24'd0, pop_entry.data_byte} << byte_sh);
                     [4'd4:4'd7]: b_in = b0 + ({24'd0, pop_entry.data_byte} << byte_sh);
                     [4'd8:4'd10]: begin
                        pend_in = pend0 | ({16'd0, pop_entry.data_byte} << byte_sh);
                     end
                     default: begin
                        // Twelfth byte: complete word c and mix the block.
                        c_in     = c0 + {pop_entry.data_byte, pend0};
                        pend_in  = '0;
                        state_in = bsmh_pkg::ST_MIX;
                     end
                  endcase
               end
            end
         end
         bsmh_pkg::ST_MIX: begin
            case (role_ff)
               bsmh_pkg::ROLE_A: a_in = mix_new;
               bsmh_pkg::ROLE_B: b_in = mix_new;
               default:          c_in = mix_new;
            endcase
            step_in = step_ff + 4'd1;
            role_in = (role_ff == bsmh_pkg::ROLE_C) ? bsmh_pkg::ROLE_A : role_ff + 2'd1;
            if (step_ff == bsmh_pkg::MIX_LAST_STEP) begin
               if (fin_ff) begin
                  state_in = bsmh_pkg::ST_EMIT;
               end else if (close_ff) begin
                  state_in = bsmh_pkg::ST_FINAL;
               end else begin
                  state_in = bsmh_pkg::ST_TAKE;
               end
            end
         end
         bsmh_pkg::ST_FINAL: begin
            // Length and tail bytes of word c, then the final mix.
            c_in     = c_ff + len_ff + {pend_ff, 8'd0};
            pend_in  = '0;
            step_in  = '0;
            role_in  = bsmh_pkg::ROLE_A;
            fin_in   = 1'b1;
            state_in = bsmh_pkg::ST_MIX;
         end
         bsmh_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               hash_in      = c_ff;
               rsp_valid_in = 1'b1;
               pos_in       = '0;
               close_in     = 1'b0;
               fin_in       = 1'b0;
               state_in     = bsmh_pkg::ST_TAKE;
            end
         end
         default: state_in = bsmh_pkg::ST_TAKE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsmh_pkg::ST_TAKE;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
         close_ff     <= 1'b0;
         step_ff      <= '0;
         role_ff      <= bsmh_pkg::ROLE_A;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
         close_ff     <= close_in;
         step_ff      <= step_in;
         role_ff      <= role_in;
      end
   end

   // Hash words and result; every message reloads the hash words on its first word.
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      pend_ff <= pend_in;
      pos_ff  <= pos_in;
      len_ff  <= len_in;
      hash_ff <= hash_in;
   end

endmodule

@@ rtl/core/byte_stream_mix_hash_32.sv @@
// A message's last word is taken in ST_TAKE; ST_FINAL adds the length and tail bytes, ST_MIX runs
// the mix and ST_EMIT registers the hash once any held result is taken. When that word's byte
// completes a 12-byte block, that block is mixed first. The queue holds each word in a register slot.
// The back end takes a byte word in ST_TAKE and mixes a block one step per cycle, taking no word
// meanwhile; the front end keeps accepting words into the queue while the queue has room.
// Reset (synchronous, active high) empties the queue, drops any result and closes messages.
module byte_stream_mix_hash_32 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_item,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);

   bsmh_pkg::entry_type push_entry;
   bsmh_pkg::entry_type pop_entry;
   logic                push_valid;
   logic                push_ready;
   logic                pop_valid;
   logic                pop_ready;

   // Accept and classify words.
   bsmh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last_item    (req_last_item),
      .req_seed         (req_seed),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   // Decouple the two ends.
   bsmh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Hash the bytes and deliver results.
   bsmh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

@@ rtl/core/bsmh_checker.sv @@
// Port-level checker of the hash block and its bind to the top level.
`include "assert_macros.svh"

module bsmh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_item,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash_value
);

   logic [7:0] open_ff;
   logic [7:0] open_in;
   logic       req_close;
   logic       rsp_take;

   assign req_close = req_valid && req_ready && req_last_item;
   assign rsp_take  = rsp_valid && rsp_ready;

   // Count closed messages whose hash has not yet been delivered.
   always_comb begin
      open_in = open_ff;
      if (req_close && !rsp_take) begin
         open_in = open_ff + 8'd1;
      end else if (rsp_take && !req_close) begin
         open_in = open_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // A held result keeps its value until it is taken.
   `BSMH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value), "result changed while stalled")
   // A result appears only for a message whose last word was accepted.
   `BSMH_ASSERT(a_rsp_owed, clock, reset, rsp_valid |-> open_ff != 8'd0, "result without a closed message")
   // No result is shown right after reset.
   `BSMH_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind byte_stream_mix_hash_32 bsmh_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last_item  (req_last_item),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value)
);
